### hw/rtl/nczit_pkg.sv
package nczit_pkg;

    localparam int DEF_MAX_INTERVALS = 64;
    localparam int DEF_COORD_WIDTH   = 32;
    localparam int WIND_W            = 16;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_COVERS = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SC_RD,
        S_SC_CHK,
        S_M1,
        S_REL_RD,
        S_REL_CHK,
        S_M2,
        S_ADV_A,
        S_ADV_B,
        S_M3,
        S_M4,
        S_TAIL,
        S_D_INIT,
        S_D_LOOP,
        S_D_WR,
        S_P_INIT,
        S_P_LOOP,
        S_P_WR,
        S_CV_RD,
        S_CV_CHK,
        S_RES0
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RD_P,
        CMD_SCAN_NEXT,
        CMD_LATCH_R,
        CMD_WR_EXTEND,
        CMD_SET_YS_RLO,
        CMD_WR_LOW,
        CMD_PE_YS_YE,
        CMD_PE_YS_RLO,
        CMD_PE_RLO_YS,
        CMD_PE_RLO_RHI,
        CMD_ADV_A,
        CMD_ADV_B,
        CMD_MID_WR,
        CMD_MID_SKIP,
        CMD_DK_INIT,
        CMD_RD_K1,
        CMD_WR_K_SHIFT,
        CMD_DEC,
        CMD_PK_INIT,
        CMD_RD_KM1,
        CMD_WR_K_DN,
        CMD_PUT_FIN,
        CMD_CV_STEP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        logic      res;
        logic      res_covered;
        logic      res_full;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic out_valid;
        logic p_lt_cnt;
        logic p1_eq_cnt;
        logic p_gt_cnt;
        logic k1_lt_cnt;
        logic k_gt_p;
        logic cnt_ge_max;
        logic cnt_full2;
        logic empty_or_zero;
        logic ys_gt_mhi;
        logic ys_ge_mhi;
        logic ys_lt_mlo;
        logic ye_le_mhi;
        logic ys_ge_ye;
        logic rhi_eq_ys;
        logic rd_eq_d;
        logic ye_lt_rlo;
        logic ye_eq_rlo;
        logic ys_lt_rlo;
        logic rlo_lt_ys;
        logic nd_zero;
        logic rlo_lt_rhi;
    } t_status;

endpackage

### hw/rtl/nczit_ram.sv
module nczit_ram
    import nczit_pkg::*;
#(
    parameter int WIDTH = 80,
    parameter int DEPTH = DEF_MAX_INTERVALS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/nczit_datapath.sv
module nczit_datapath
    import nczit_pkg::*;
#(
    parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
    parameter int COORD_WIDTH   = DEF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic                          i_op,
    input  logic signed [COORD_WIDTH-1:0] i_y_start,
    input  logic signed [COORD_WIDTH-1:0] i_y_end,
    input  logic signed [1:0]             i_direction,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_covered,
    output logic                          o_full_res
);

    localparam int AW    = $clog2(MAX_INTERVALS);
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int EW    = 2 * COORD_WIDTH + WIND_W;

    logic signed [COORD_WIDTH-1:0] r_ys, n_ys, r_ye, r_rlo, n_rlo, r_rhi, n_rhi;
    logic signed [COORD_WIDTH-1:0] r_pe_lo, n_pe_lo, r_pe_hi, n_pe_hi;
    logic signed [WIND_W-1:0]      r_rd, n_rd, r_pe_c, n_pe_c;
    logic signed [1:0]             r_d;
    logic                          r_op;
    logic [CNT_W-1:0]              r_p, n_p, r_k, n_k, r_cnt, n_cnt;
    logic                          r_out_valid, r_covered, r_full_res;

    logic                          we, re;
    logic [AW-1:0]                 waddr, raddr;
    logic [EW-1:0]                 wdata, rdata;
    logic signed [COORD_WIDTH-1:0] m_lo, m_hi, ne;
    logic signed [WIND_W-1:0]      d_ext, nd;
    logic signed [WIND_W:0]        sum;
    logic [CNT_W:0]                cnt_w, p_w, k_w;

    nczit_ram #(.WIDTH(EW), .DEPTH(MAX_INTERVALS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign m_lo  = rdata[EW-1 -: COORD_WIDTH];
    assign m_hi  = rdata[WIND_W +: COORD_WIDTH];
    assign d_ext = {{(WIND_W-2){r_d[1]}}, r_d};
    assign sum   = {r_rd[WIND_W-1], r_rd} + {{(WIND_W-1){r_d[1]}}, r_d};
    assign ne    = (r_ye < r_rhi) ? r_ye : r_rhi;
    assign cnt_w = {1'b0, r_cnt};
    assign p_w   = {1'b0, r_p};
    assign k_w   = {1'b0, r_k};

    always_comb begin
        if (sum > $signed({2'b00, {(WIND_W-1){1'b1}}})) begin
            nd = {1'b0, {(WIND_W-1){1'b1}}};
        end else if (sum < $signed({2'b11, {(WIND_W-1){1'b0}}})) begin
            nd = {1'b1, {(WIND_W-1){1'b0}}};
        end else begin
            nd = sum[WIND_W-1:0];
        end
    end

    always_comb begin
        o_status.op            = r_op;
        o_status.out_valid     = r_out_valid;
        o_status.p_lt_cnt      = r_p < r_cnt;
        o_status.p1_eq_cnt     = (p_w + 1'b1) == cnt_w;
        o_status.p_gt_cnt      = r_p > r_cnt;
        o_status.k1_lt_cnt     = (k_w + 1'b1) < cnt_w;
        o_status.k_gt_p        = r_k > r_p;
        o_status.cnt_ge_max    = cnt_w >= (CNT_W+1)'(MAX_INTERVALS);
        o_status.cnt_full2     = (cnt_w + 2'd2) > (CNT_W+1)'(MAX_INTERVALS);
        o_status.empty_or_zero = (r_ys >= r_ye) || (r_d == 2'sd0);
        o_status.ys_gt_mhi     = r_ys > m_hi;
        o_status.ys_ge_mhi     = r_ys >= m_hi;
        o_status.ys_lt_mlo     = r_ys < m_lo;
        o_status.ye_le_mhi     = r_ye <= m_hi;
        o_status.ys_ge_ye      = r_ys >= r_ye;
        o_status.rhi_eq_ys     = r_rhi == r_ys;
        o_status.rd_eq_d       = r_rd == d_ext;
        o_status.ye_lt_rlo     = r_ye < r_rlo;
        o_status.ye_eq_rlo     = r_ye == r_rlo;
        o_status.ys_lt_rlo     = r_ys < r_rlo;
        o_status.rlo_lt_ys     = r_rlo < r_ys;
        o_status.nd_zero       = nd == '0;
        o_status.rlo_lt_rhi    = r_rlo < r_rhi;
    end

    always_comb begin
        n_ys    = r_ys;
        n_rlo   = r_rlo;
        n_rhi   = r_rhi;
        n_rd    = r_rd;
        n_pe_lo = r_pe_lo;
        n_pe_hi = r_pe_hi;
        n_pe_c  = r_pe_c;
        n_p     = r_p;
        n_k     = r_k;
        n_cnt   = r_cnt;
        we      = 1'b0;
        re      = 1'b0;
        waddr   = r_p[AW-1:0];
        raddr   = r_p[AW-1:0];
        wdata   = rdata;
        case (i_cmd.kind)
            CMD_LOAD: begin
                n_ys = i_y_start;
                n_p  = '0;
            end
            CMD_RD_P: re = 1'b1;
            CMD_SCAN_NEXT: n_p = r_p + 1'b1;
            CMD_LATCH_R: begin
                n_rlo = m_lo;
                n_rhi = m_hi;
                n_rd  = rdata[WIND_W-1:0];
            end
            CMD_WR_EXTEND: begin
                we    = 1'b1;
                wdata = {r_rlo, r_ye, r_rd};
            end
            CMD_SET_YS_RLO: n_ys = r_rlo;
            CMD_WR_LOW: begin
                we    = 1'b1;
                wdata = {r_ys, r_rhi, r_rd};
            end
            CMD_PE_YS_YE: begin
                n_pe_lo = r_ys;
                n_pe_hi = r_ye;
                n_pe_c  = d_ext;
            end
            CMD_PE_YS_RLO: begin
                n_pe_lo = r_ys;
                n_pe_hi = r_rlo;
                n_pe_c  = d_ext;
            end
            CMD_PE_RLO_YS: begin
                n_pe_lo = r_rlo;
                n_pe_hi = r_ys;
                n_pe_c  = r_rd;
            end
            CMD_PE_RLO_RHI: begin
                n_pe_lo = r_rlo;
                n_pe_hi = r_rhi;
                n_pe_c  = r_rd;
            end
            CMD_ADV_A: begin
                n_p  = r_p + 1'b1;
                n_ys = r_rlo;
            end
            CMD_ADV_B: begin
                n_p   = r_p + 1'b1;
                n_rlo = r_ys;
            end
            CMD_MID_WR: begin
                we    = 1'b1;
                wdata = {r_ys, ne, nd};
                n_p   = r_p + 1'b1;
                n_ys  = ne;
                n_rlo = ne;
            end
            CMD_MID_SKIP: begin
                n_ys  = ne;
                n_rlo = ne;
            end
            CMD_DK_INIT: n_k = r_p;
            CMD_RD_K1: begin
                re    = 1'b1;
                raddr = AW'(r_k + 1'b1);
            end
            CMD_WR_K_SHIFT: begin
                we    = 1'b1;
                waddr = r_k[AW-1:0];
                n_k   = r_k + 1'b1;
            end
            CMD_DEC: n_cnt = r_cnt - 1'b1;
            CMD_PK_INIT: n_k = r_cnt;
            CMD_RD_KM1: begin
                re    = 1'b1;
                raddr = AW'(r_k - 1'b1);
            end
            CMD_WR_K_DN: begin
                we    = 1'b1;
                waddr = r_k[AW-1:0];
                n_k   = r_k - 1'b1;
            end
            CMD_PUT_FIN: begin
                we    = 1'b1;
                wdata = {r_pe_lo, r_pe_hi, r_pe_c};
                n_cnt = r_cnt + 1'b1;
            end
            CMD_CV_STEP: begin
                n_ys = m_hi;
                n_p  = r_p + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ys    <= n_ys;
        r_rlo   <= n_rlo;
        r_rhi   <= n_rhi;
        r_rd    <= n_rd;
        r_pe_lo <= n_pe_lo;
        r_pe_hi <= n_pe_hi;
        r_pe_c  <= n_pe_c;
        r_p     <= n_p;
        r_k     <= n_k;
        if (i_cmd.kind == CMD_LOAD) begin
            r_ye <= i_y_end;
            r_d  <= i_direction;
            r_op <= i_op;
        end
        if (i_cmd.res) begin
            r_covered  <= i_cmd.res_covered;
            r_full_res <= i_cmd.res_full;
        end
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.res) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_covered   = r_covered;
    assign o_full_res  = r_full_res;

endmodule

### hw/rtl/nczit_ctrl.sv
module nczit_ctrl
    import nczit_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state, r_ret, n_ret;
    t_status s;

    assign s       = i_status;
    assign o_ready = (r_state == S_IDLE) && !s.out_valid;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            S_IDLE:     if (i_valid && o_ready) n_state = S_DISPATCH;
            S_DISPATCH: begin
                if (s.op == OP_COVERS) n_state = S_CV_RD;
                else if (s.cnt_full2 || s.empty_or_zero) n_state = S_IDLE;
                else n_state = S_SC_RD;
            end
            S_SC_RD:    n_state = s.p_lt_cnt ? S_SC_CHK : S_TAIL;
            S_SC_CHK:   n_state = s.ys_gt_mhi ? S_SC_RD : S_M1;
            S_M1: begin
                if (s.rhi_eq_ys && s.rd_eq_d) begin
                    if (s.p1_eq_cnt) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ret   = S_REL_RD;
                        n_state = S_D_INIT;
                    end
                end else begin
                    n_state = S_M2;
                end
            end
            S_REL_RD:   n_state = S_REL_CHK;
            S_REL_CHK:  n_state = S_M2;
            S_M2: begin
                if (s.ye_lt_rlo) begin
                    n_ret   = S_RES0;
                    n_state = S_P_INIT;
                end else if (s.ye_eq_rlo && s.rd_eq_d) begin
                    n_state = S_IDLE;
                end else if (s.ys_lt_rlo) begin
                    n_ret   = S_ADV_A;
                    n_state = S_P_INIT;
                end else if (s.rlo_lt_ys) begin
                    n_ret   = S_ADV_B;
                    n_state = S_P_INIT;
                end else begin
                    n_state = S_M3;
                end
            end
            S_ADV_A, S_ADV_B: n_state = S_M3;
            S_M3: begin
                if (s.nd_zero) begin
                    n_ret   = S_M4;
                    n_state = S_D_INIT;
                end else begin
                    n_state = S_M4;
                end
            end
            S_M4: begin
                if (s.rlo_lt_rhi) begin
                    n_ret   = S_TAIL;
                    n_state = S_P_INIT;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                if (!s.ys_ge_ye) begin
                    n_ret   = S_RES0;
                    n_state = S_P_INIT;
                end else begin
                    n_state = S_RES0;
                end
            end
            S_D_INIT:   n_state = s.p_lt_cnt ? S_D_LOOP : r_ret;
            S_D_LOOP:   n_state = s.k1_lt_cnt ? S_D_WR : r_ret;
            S_D_WR:     n_state = S_D_LOOP;
            S_P_INIT:   n_state = (s.cnt_ge_max || s.p_gt_cnt) ? r_ret : S_P_LOOP;
            S_P_LOOP:   n_state = s.k_gt_p ? S_P_WR : r_ret;
            S_P_WR:     n_state = S_P_LOOP;
            S_CV_RD:    n_state = s.p_lt_cnt ? S_CV_CHK : S_IDLE;
            S_CV_CHK: begin
                if (s.ys_ge_mhi) n_state = S_CV_RD;
                else if (s.ys_lt_mlo || s.ye_le_mhi) n_state = S_IDLE;
                else n_state = S_CV_RD;
            end
            S_RES0:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '{kind: CMD_NONE, res: 1'b0, res_covered: 1'b0, res_full: 1'b0};
        case (r_state)
            S_IDLE:     if (i_valid && o_ready) o_cmd.kind = CMD_LOAD;
            S_DISPATCH: begin
                if (s.op == OP_RECORD) begin
                    if (s.cnt_full2) begin
                        o_cmd.res      = 1'b1;
                        o_cmd.res_full = 1'b1;
                    end else if (s.empty_or_zero) begin
                        o_cmd.res = 1'b1;
                    end
                end
            end
            S_SC_RD:    if (s.p_lt_cnt) o_cmd.kind = CMD_RD_P;
            S_SC_CHK:   o_cmd.kind = s.ys_gt_mhi ? CMD_SCAN_NEXT : CMD_LATCH_R;
            S_M1: begin
                if (s.rhi_eq_ys && s.rd_eq_d) begin
                    if (s.p1_eq_cnt) begin
                        o_cmd.kind = CMD_WR_EXTEND;
                        o_cmd.res  = 1'b1;
                    end else begin
                        o_cmd.kind = CMD_SET_YS_RLO;
                    end
                end
            end
            S_REL_RD:   o_cmd.kind = CMD_RD_P;
            S_REL_CHK:  o_cmd.kind = CMD_LATCH_R;
            S_M2: begin
                if (s.ye_lt_rlo) begin
                    o_cmd.kind = CMD_PE_YS_YE;
                end else if (s.ye_eq_rlo && s.rd_eq_d) begin
                    o_cmd.kind = CMD_WR_LOW;
                    o_cmd.res  = 1'b1;
                end else if (s.ys_lt_rlo) begin
                    o_cmd.kind = CMD_PE_YS_RLO;
                end else if (s.rlo_lt_ys) begin
                    o_cmd.kind = CMD_PE_RLO_YS;
                end
            end
            S_ADV_A:    o_cmd.kind = CMD_ADV_A;
            S_ADV_B:    o_cmd.kind = CMD_ADV_B;
            S_M3: begin
                if (!s.nd_zero && s.p_lt_cnt) o_cmd.kind = CMD_MID_WR;
                else o_cmd.kind = CMD_MID_SKIP;
            end
            S_M4:       if (s.rlo_lt_rhi) o_cmd.kind = CMD_PE_RLO_RHI;
            S_TAIL:     if (!s.ys_ge_ye) o_cmd.kind = CMD_PE_YS_YE;
            S_D_INIT:   if (s.p_lt_cnt) o_cmd.kind = CMD_DK_INIT;
            S_D_LOOP:   o_cmd.kind = s.k1_lt_cnt ? CMD_RD_K1 : CMD_DEC;
            S_D_WR:     o_cmd.kind = CMD_WR_K_SHIFT;
            S_P_INIT:   if (!(s.cnt_ge_max || s.p_gt_cnt)) o_cmd.kind = CMD_PK_INIT;
            S_P_LOOP:   o_cmd.kind = s.k_gt_p ? CMD_RD_KM1 : CMD_PUT_FIN;
            S_P_WR:     o_cmd.kind = CMD_WR_K_DN;
            S_CV_RD: begin
                if (s.p_lt_cnt) begin
                    o_cmd.kind = CMD_RD_P;
                end else begin
                    o_cmd.res         = 1'b1;
                    o_cmd.res_covered = s.ys_ge_ye;
                end
            end
            S_CV_CHK: begin
                if (s.ys_ge_mhi) begin
                    o_cmd.kind = CMD_SCAN_NEXT;
                end else if (s.ys_lt_mlo) begin
                    o_cmd.res = 1'b1;
                end else if (s.ye_le_mhi) begin
                    o_cmd.res         = 1'b1;
                    o_cmd.res_covered = 1'b1;
                end else begin
                    o_cmd.kind = CMD_CV_STEP;
                end
            end
            S_RES0:     o_cmd.res = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

endmodule

### hw/rtl/nonzero_crossing_interval_table.sv
// Sorted table of nonzero-winding y intervals held in one single-port-write,
// registered-read RAM. A covers query reads the table once, entry by entry.
// A record scans to its place the same way and then moves entries one at a
// time for every insert or removal, shifting the tail of the table. One
// transaction is in work at a time; the next is taken once the result has
// been taken.
module nonzero_crossing_interval_table
    import nczit_pkg::*;
#(
    parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
    parameter int COORD_WIDTH   = DEF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic signed [COORD_WIDTH-1:0] i_y_start,
    input  logic signed [COORD_WIDTH-1:0] i_y_end,
    input  logic signed [1:0]             i_direction,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_covered,
    output logic                          o_full_res
);

    t_cmd    cmd;
    t_status status;

    nczit_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    nczit_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .COORD_WIDTH   (COORD_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_op        (i_op),
        .i_y_start   (i_y_start),
        .i_y_end     (i_y_end),
        .i_direction (i_direction),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_covered   (o_covered),
        .o_full_res  (o_full_res)
    );

endmodule
